### rtl/gregorian_date_difference_defines.svh
`ifndef GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH

// Check that a property holds on every clock edge out of reset.
`define GDD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs on a clock edge out of reset.
`define GDD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/gdd_pkg.sv
package gdd_pkg;

  // Request carried on the input channel
  typedef struct packed {
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
  } gdd_in_t;

  // Result carried on the output channel
  typedef struct packed {
    logic [2:0]  weekday;
    logic [16:0] month_gap;
    logic [13:0] year_gap;
    logic [21:0] day_gap;
  } gdd_out_t;

  // Configuration write
  typedef struct packed {
    logic [1:0]  addr;
    logic [13:0] wdata;
  } gdd_cfg_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_SAVED_DAY   = 2'd0;
  localparam logic [1:0] CFG_SAVED_MONTH = 2'd1;
  localparam logic [1:0] CFG_SAVED_YEAR  = 2'd2;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_YEAR,
    OP_SPLIT_YEAR,
    OP_WEEK_SUM,
    OP_WEEK_MOD,
    OP_YEAR_BASE,
    OP_DATE,
    OP_MONTH_GAP,
    OP_MONTH_MUL,
    OP_MONTH_QUO,
    OP_DAY_GAP,
    OP_EMIT
  } gdd_op_e;

  // Controller to datapath command; sel picks the compared date over the reference
  typedef struct packed {
    gdd_op_e op;
    logic    sel;
  } gdd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } gdd_status_t;

  // Reciprocals: y / 100 = (y * K100) >> 21 for y < 43690,
  // x / 3 = (x * K3) >> 17 for x < 131072
  localparam logic [15:0] K100 = 16'd20972;
  localparam logic [15:0] K3   = 16'd43691;

  // Days before the start of month (index 0 is January)
  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  // Month term (31 * shifted month) / 12 of the weekday congruence, by raw month
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd0:    r = 6'd25;
      4'd1:    r = 6'd28;
      4'd2:    r = 6'd31;
      4'd3:    r = 6'd2;
      4'd4:    r = 6'd5;
      4'd5:    r = 6'd7;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd12;
      4'd8:    r = 6'd15;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd20;
      4'd11:   r = 6'd23;
      4'd12:   r = 6'd25;
      4'd13:   r = 6'd28;
      4'd14:   r = 6'd31;
      default: r = 6'd33;
    endcase
    return r;
  endfunction

endpackage

### rtl/gdd_if.sv
// Input date channel
interface gdd_in_if ();
  import gdd_pkg::*;
  logic    valid;
  logic    ready;
  gdd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface gdd_out_if ();
  import gdd_pkg::*;
  logic     valid;
  logic     ready;
  gdd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel
interface gdd_cfg_if ();
  import gdd_pkg::*;
  logic     valid;
  logic     ready;
  gdd_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gdd_ctrl.sv
`include "gregorian_date_difference_defines.svh"

module gdd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gdd_pkg::gdd_status_t status_i,
  output gdd_pkg::gdd_cmd_t    cmd_o
);
  import gdd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DMUL = 4'd1;
  localparam logic [3:0] ST_DQUO = 4'd2;
  localparam logic [3:0] ST_WSUM = 4'd3;
  localparam logic [3:0] ST_WMOD = 4'd4;
  localparam logic [3:0] ST_YEAR = 4'd5;
  localparam logic [3:0] ST_DATE = 4'd6;
  localparam logic [3:0] ST_MGAP = 4'd7;
  localparam logic [3:0] ST_MMUL = 4'd8;
  localparam logic [3:0] ST_MQUO = 4'd9;
  localparam logic [3:0] ST_DGAP = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0] st_q, st_d;
  logic       sel_q, sel_d;

  // Sequence one request: reference date, compared date, then the gaps
  always_comb begin
    st_d       = st_q;
    sel_d      = sel_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = sel_q;
    in_ready_o = (st_q == ST_IDLE);
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          sel_d    = 1'b0;
          st_d     = ST_DMUL;
        end
      end
      ST_DMUL: begin
        cmd_o.op = OP_DIV_YEAR;
        st_d     = ST_DQUO;
      end
      ST_DQUO: begin
        cmd_o.op = OP_SPLIT_YEAR;
        st_d     = sel_q ? ST_YEAR : ST_WSUM;
      end
      ST_WSUM: begin
        cmd_o.op = OP_WEEK_SUM;
        st_d     = ST_WMOD;
      end
      ST_WMOD: begin
        cmd_o.op = OP_WEEK_MOD;
        st_d     = ST_YEAR;
      end
      ST_YEAR: begin
        cmd_o.op = OP_YEAR_BASE;
        st_d     = ST_DATE;
      end
      ST_DATE: begin
        cmd_o.op = OP_DATE;
        if (!sel_q) begin
          sel_d = 1'b1;
          st_d  = ST_DMUL;
        end else begin
          st_d = ST_MGAP;
        end
      end
      ST_MGAP: begin
        cmd_o.op = OP_MONTH_GAP;
        st_d     = ST_MMUL;
      end
      ST_MMUL: begin
        cmd_o.op = OP_MONTH_MUL;
        st_d     = ST_MQUO;
      end
      ST_MQUO: begin
        cmd_o.op = OP_MONTH_QUO;
        st_d     = ST_DGAP;
      end
      ST_DGAP: begin
        cmd_o.op = OP_DAY_GAP;
        st_d     = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      sel_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      sel_q <= sel_d;
    end
  end

  `GDD_ASSERT(a_accept_starts, (st_q == ST_IDLE && in_valid_i) |=> (st_q == ST_DMUL), "accepted request did not start")
  `GDD_ASSERT(a_emit_free, (cmd_o.op == OP_EMIT) |-> status_i.out_free, "result emitted into a full output register")
  `GDD_ASSERT_NEVER(a_week_on_ref, (st_q == ST_WSUM || st_q == ST_WMOD) && sel_q, "weekday computed on the compared date")

endmodule

### rtl/gdd_datapath.sv
`include "gregorian_date_difference_defines.svh"

module gdd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  gdd_pkg::gdd_cfg_t    cfg_i,
  input  gdd_pkg::gdd_in_t     in_i,
  input  gdd_pkg::gdd_cmd_t    cmd_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output gdd_pkg::gdd_out_t    out_o,
  output gdd_pkg::gdd_status_t status_o
);
  import gdd_pkg::*;

  localparam logic [14:0] WD_BASE   = 15'd7000;
  localparam logic [22:0] DAYS_YEAR = 23'd365;
  localparam logic [13:0] HUNDRED   = 14'd100;
  localparam logic [17:0] MONTHS    = 18'd12;

  // Weekday residue by folding octal digits (8 is 1 modulo 7)
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    f1 = {3'd0, v[2:0]} + {3'd0, v[5:3]} + {3'd0, v[8:6]} + {3'd0, v[11:9]}
       + {3'd0, v[14:12]};
    f2 = {1'b0, f1[5:3]} + {1'b0, f1[2:0]};
    f3 = {3'd0, f2[3]} + {1'b0, f2[2:0]};
    return (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
  endfunction

  // Reference date and captured request
  logic [4:0]  sav_day_q, oth_day_q;
  logic [3:0]  sav_month_q, oth_month_q;
  logic [13:0] sav_year_q, oth_year_q;

  // Working registers
  logic [31:0] prod_q;
  logic [7:0]  q100_q;
  logic        rz_q;
  logic [14:0] s_q;
  logic [2:0]  weekday_q;
  logic [22:0] base_q;
  logic        leap_q;
  logic [22:0] ord_q [2];
  logic [17:0] mg_q;
  logic [13:0] yg_q;
  logic [21:0] dg_q;
  gdd_out_t    out_q;
  logic        out_valid_q;

  // Combinational values
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [13:0] cur_year;
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod_d;
  logic [7:0]  q100_w;
  logic [13:0] hund_w;
  logic [12:0] c4, leaps;
  logic [8:0]  c100;
  logic [6:0]  c400;
  logic [22:0] base_d;
  logic        leap_d;
  logic [3:0]  mc_idx;
  logic [22:0] ord_d;
  logic        wa;
  logic [13:0] yy;
  logic [7:0]  yq100;
  logic [14:0] wy, s_d;
  logic [17:0] m_oth, m_sav, mg_d;
  logic [14:0] yq_w;
  logic [22:0] dg_w;

  // Write configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sav_day_q   <= 5'd1;
      sav_month_q <= 4'd1;
      sav_year_q  <= 14'd2000;
    end else if (cfg_we_i) begin
      unique case (cfg_i.addr)
        CFG_SAVED_DAY:   sav_day_q   <= cfg_i.wdata[4:0];
        CFG_SAVED_MONTH: sav_month_q <= cfg_i.wdata[3:0];
        CFG_SAVED_YEAR:  sav_year_q  <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Select the date under work
  assign cur_day   = cmd_i.sel ? oth_day_q : sav_day_q;
  assign cur_month = cmd_i.sel ? oth_month_q : sav_month_q;
  assign cur_year  = cmd_i.sel ? oth_year_q : sav_year_q;

  // Shared reciprocal multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_DIV_YEAR: begin
        mul_a = {2'd0, cur_year};
        mul_b = K100;
      end
      OP_MONTH_MUL: begin
        mul_a = mg_q[17:2];
        mul_b = K3;
      end
      default: ;
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // Split year into hundreds and a zero-remainder flag
  assign q100_w = prod_q[28:21];
  assign hund_w = {6'd0, q100_w} * HUNDRED;

  // Days before 1 January of the year: 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
  assign c4     = {1'b0, cur_year[13:2]} + {12'd0, |cur_year[1:0]};
  assign c100   = {1'b0, q100_q} + {8'd0, !rz_q};
  assign c400   = {1'b0, q100_q[7:2]} + {6'd0, (!rz_q || (q100_q[1:0] != 2'b00))};
  assign leaps  = c4 - {4'd0, c100} + {6'd0, c400};
  assign base_d = ({9'd0, cur_year} * DAYS_YEAR) + {10'd0, leaps};
  assign leap_d = ((cur_year[1:0] == 2'b00) && !rz_q) || (rz_q && (q100_q[1:0] == 2'b00));

  // Day number: clamp month, add month start, leap day and day of month
  always_comb begin
    if (cur_month == 4'd0) begin
      mc_idx = 4'd0;
    end else if (cur_month > 4'd12) begin
      mc_idx = 4'd11;
    end else begin
      mc_idx = cur_month - 4'd1;
    end
  end
  assign ord_d = base_q + {14'd0, days_before(mc_idx)}
               + {22'd0, (mc_idx >= 4'd2) && leap_q} + {18'd0, cur_day};

  // Weekday congruence on the reference date; January and February count
  // in the previous year, which is minus one for year zero
  assign wa    = (sav_month_q <= 4'd2);
  assign yy    = wa ? sav_year_q - 14'd1 : sav_year_q;
  assign yq100 = wa ? q100_q - {7'd0, rz_q} : q100_q;
  assign wy    = {1'b0, yy} + {3'd0, yy[13:2]} + {9'd0, yq100[7:2]} - {7'd0, yq100};
  assign s_d   = WD_BASE + {10'd0, sav_day_q} + {9'd0, month_term(sav_month_q)}
               + ((wa && (sav_year_q == 14'd0)) ? 15'h7FFF : wy);

  // Month and day gaps
  assign m_oth = ({4'd0, oth_year_q} * MONTHS) + {14'd0, oth_month_q};
  assign m_sav = ({4'd0, sav_year_q} * MONTHS) + {14'd0, sav_month_q};
  assign mg_d  = (m_oth > m_sav) ? m_oth - m_sav : m_sav - m_oth;
  assign yq_w  = prod_q[31:17];
  assign dg_w  = (ord_q[0] > ord_q[1]) ? ord_q[0] - ord_q[1] : ord_q[1] - ord_q[0];

  // Advance the working registers under the controller's command
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        oth_day_q   <= in_i.other_day;
        oth_month_q <= in_i.other_month;
        oth_year_q  <= in_i.other_year;
      end
      OP_DIV_YEAR, OP_MONTH_MUL: prod_q <= prod_d;
      OP_SPLIT_YEAR: begin
        q100_q <= q100_w;
        rz_q   <= (cur_year == hund_w);
      end
      OP_WEEK_SUM:  s_q       <= s_d;
      OP_WEEK_MOD:  weekday_q <= mod7(s_q);
      OP_YEAR_BASE: begin
        base_q <= base_d;
        leap_q <= leap_d;
      end
      OP_DATE:      ord_q[cmd_i.sel] <= ord_d;
      OP_MONTH_GAP: mg_q <= mg_d;
      OP_MONTH_QUO: yg_q <= (yq_w > 15'd16383) ? 14'h3FFF : yq_w[13:0];
      OP_DAY_GAP:   dg_q <= dg_w[22] ? 22'h3FFFFF : dg_w[21:0];
      OP_EMIT: begin
        out_q.weekday   <= weekday_q;
        out_q.month_gap <= mg_q[17] ? 17'h1FFFF : mg_q[16:0];
        out_q.year_gap  <= yg_q;
        out_q.day_gap   <= dg_q;
      end
      default: ;
    endcase
  end

  // Output register valid: set on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  `GDD_ASSERT(a_emit_sets_valid, (cmd_i.op == OP_EMIT) |=> out_valid_q, "emitted result not presented")
  `GDD_ASSERT(a_year_quo_range, (cmd_i.op == OP_MONTH_QUO) |-> (prod_q[31:17] <= 15'd16384), "month quotient out of range")

endmodule

### rtl/gregorian_date_difference.sv
// Gregorian date comparison block.
// A reference date is written through cfg_chan_i (index 0 day, 1 month,
// 2 year); the channel is always ready and writes beyond index 2 are dropped.
// Write it only while no request is in flight.
// Each request on in_chan_i carries a second date. One result leaves on
// out_chan_o per request: weekday of the reference date (0 is Sunday), the
// month gap, that gap divided by twelve and the day gap, each saturated.
// A single controller walks both dates through one shared reciprocal
// multiplier, and a new request is taken only once the last one has moved
// into the output register.
// When the receiver stalls the result holds in the output register, the
// next request is still taken and worked, and it waits in its last step
// until the output register frees.
// Reset restores the reference date to 1 January 2000 and drops any result.
module gregorian_date_difference (
  input logic       clk_i,
  input logic       rst_ni,
  gdd_in_if.sink    in_chan_i,
  gdd_out_if.source out_chan_o,
  gdd_cfg_if.sink   cfg_chan_i
);
  import gdd_pkg::*;

  gdd_cmd_t    cmd;
  gdd_status_t status;
  logic        in_ready;
  logic        out_valid;
  gdd_out_t    out_data;

  // Always take configuration writes
  assign cfg_chan_i.ready = 1'b1;

  gdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gdd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_chan_i.valid),
    .cfg_i       (cfg_chan_i.data),
    .in_i        (in_chan_i.data),
    .cmd_i       (cmd),
    .out_ready_i (out_chan_o.ready),
    .out_valid_o (out_valid),
    .out_o       (out_data),
    .status_o    (status)
  );

  assign in_chan_i.ready  = in_ready;
  assign out_chan_o.valid = out_valid;
  assign out_chan_o.data  = out_data;

endmodule
